// File: sv/rsnr_pkg.sv
// Package for the roulette selection block without replacement.
// Holds widths, item kind codes, status codes and the control state type.
// No dependencies; imported by roulette_selection_no_replace.
package rsnr_pkg;

	localparam int MAX_ENTRIES = 256;
	localparam int IDX_W       = $clog2(MAX_ENTRIES);
	localparam int CNT_W       = IDX_W + 1;
	localparam int FIT_W       = 32;
	localparam int SUM_W       = 40;
	localparam int HALF_W      = SUM_W / 2;
	localparam int FRAC_W      = 16;
	localparam int KIND_W      = 2;
	localparam int PROD_W      = FRAC_W + HALF_W;
	localparam int WIDE_W      = FRAC_W + SUM_W;

	localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_START = 2'd1;
	localparam logic [KIND_W-1:0] KIND_DRAW  = 2'd2;

	localparam logic STATUS_OK    = 1'b0;
	localparam logic STATUS_EMPTY = 1'b1;

	localparam logic [CNT_W-1:0] IN_USE_RESET = CNT_W'(MAX_ENTRIES);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SUM,
		ST_MUL,
		ST_ADD,
		ST_WALK,
		ST_DONE
	} state_t;

endpackage

// File: sv/roulette_selection_no_replace.sv
// Roulette-wheel selection without replacement over a table of 256 unsigned
// 32-bit fitness values. Depends on rsnr_pkg.
//
// A load word (kind 0) writes one table entry; the block stays ready after it
// is accepted. A start word (kind 1) walks the whole table, one entry per
// cycle, clearing every picked mark and summing the fitness of the entries
// in use into the remaining total. The entries in use are 0 .. n-1, n being
// entries_in_use (the cfg_q register, written through cfg_data), and values
// above 256 act as 256. The start always reads all 256 entries, since all
// marks are cleared whatever n is. A draw word (kind 2) scales the remaining
// total by random_fraction / 65536 to form a target, then walks the table
// from index 0. It picks the first unpicked entry of positive fitness at
// which the running sum of unpicked fitness reaches the target. The picked
// entry is marked and its fitness is taken off the remaining total
// (saturating at zero). A draw makes one result word; loads, starts and
// kind 3 make none. A draw with a zero total skips the walk and reports an
// empty status. Any other draw passes through the multiply, the add that
// forms the target, and the walk over the fitness and mark memories, whose
// reads are registered. A draw whose walk finds nothing reports an empty
// status with n entries walked. A full output register holds the block in
// the done state until it frees. The block takes one word at a time; a
// result waits in the output register while the next word is accepted. The
// fitness store reads as zero until an entry is loaded. The user is to write
// entries_in_use only while the block is idle; the block itself does not
// enforce it.
module roulette_selection_no_replace (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [rsnr_pkg::KIND_W-1:0] kind,
	input  logic [rsnr_pkg::IDX_W-1:0]  entry_index,
	input  logic [rsnr_pkg::FIT_W-1:0]  fitness_value,
	input  logic [rsnr_pkg::FRAC_W-1:0] random_fraction,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [rsnr_pkg::IDX_W-1:0]  picked_index,
	output logic                        status,
	output logic [rsnr_pkg::CNT_W-1:0]  entries_walked,
	input  logic                        cfg_we,
	input  logic [rsnr_pkg::CNT_W-1:0]  cfg_data
);
	import rsnr_pkg::*;

	state_t state_q, state_d;

	// fitness memory: one write port, one registered read port
	logic [FIT_W-1:0] fit_mem [MAX_ENTRIES];
	logic [FIT_W-1:0] rd_data_s1;

	// picked marks: cleared by the start pass, set by a pick
	logic mark_mem [MAX_ENTRIES];
	logic mark_rd_s1;

	// control state
	logic [CNT_W-1:0]       cfg_q;
	logic [MAX_ENTRIES-1:0] fit_vld_q;
	logic [SUM_W-1:0]       remaining_q;
	logic                   out_valid_q;
	logic [CNT_W-1:0]       rd_idx_q;
	logic                   ev_vld_s1;

	// payload
	logic [IDX_W-1:0]  ev_idx_s1;
	logic [SUM_W-1:0]  sum_q;
	logic [SUM_W-1:0]  run_q;
	logic [FRAC_W-1:0] frac_q;
	logic [PROD_W-1:0] p_lo_s1;
	logic [PROD_W-1:0] p_hi_s1;
	logic [SUM_W-1:0]  target_q;
	logic [IDX_W-1:0]  res_pick_q;
	logic              res_status_q;
	logic [CNT_W-1:0]  res_walked_q;
	logic [IDX_W-1:0]  out_pick_q;
	logic              out_status_q;
	logic [CNT_W-1:0]  out_walked_q;

	// combinational control
	logic             accept;
	logic             slot_free;
	logic             issue;
	logic             walk_start;
	logic             walk_end;
	logic             eligible;
	logic             hit;
	logic [CNT_W-1:0] n_act;
	logic [CNT_W-1:0] walk_lim;
	logic [FIT_W-1:0] fit_s1;
	logic [SUM_W:0]   run_new;
	logic [WIDE_W-1:0] wide_sum;

	// clamp the register to the table depth
	assign n_act = (cfg_q > IN_USE_RESET) ? IN_USE_RESET : cfg_q;

	// the start pass covers the whole table so that every mark is cleared
	assign walk_lim = (state_q == ST_SUM) ? IN_USE_RESET : n_act;

	// an entry never loaded reads as zero
	assign fit_s1 = fit_vld_q[ev_idx_s1] ? rd_data_s1 : '0;

	assign run_new  = {1'b0, run_q} + {{(SUM_W + 1 - FIT_W){1'b0}}, fit_s1};
	assign eligible = ev_vld_s1 && !mark_rd_s1 && (fit_s1 != '0);
	assign wide_sum = {p_hi_s1, {HALF_W{1'b0}}} + {{(WIDE_W - PROD_W){1'b0}}, p_lo_s1};

	// handshake and walk control decode
	always_comb begin
		in_ready   = (state_q == ST_IDLE);
		accept     = in_valid && in_ready;
		slot_free  = !out_valid_q || out_ready;
		issue      = ((state_q == ST_SUM) || (state_q == ST_WALK)) && (rd_idx_q < walk_lim);
		walk_end   = !ev_vld_s1 && (rd_idx_q == walk_lim);
		hit        = (state_q == ST_WALK) && eligible
			&& (run_new >= {1'b0, target_q});
		walk_start = (accept && (kind == KIND_START)) || (state_q == ST_ADD);
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					priority if (kind == KIND_START) begin
						state_d = ST_SUM;
					end else if (kind == KIND_DRAW) begin
						state_d = (remaining_q == '0) ? ST_DONE : ST_MUL;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_SUM: begin
				if (walk_end) state_d = ST_IDLE;
			end
			ST_MUL: state_d = ST_ADD;
			ST_ADD: state_d = ST_WALK;
			ST_WALK: begin
				if (hit || walk_end) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (slot_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// fitness memory: write on a load, read the walk address every cycle
	always_ff @(posedge clk) begin
		if (accept && (kind == KIND_LOAD)) begin
			fit_mem[entry_index] <= fitness_value;
		end
		rd_data_s1 <= fit_mem[rd_idx_q[IDX_W-1:0]];
	end

	// mark memory: clear each entry on the start pass, set the pick
	always_ff @(posedge clk) begin
		if ((state_q == ST_SUM) && issue) begin
			mark_mem[rd_idx_q[IDX_W-1:0]] <= 1'b0;
		end else if (hit) begin
			mark_mem[ev_idx_s1] <= 1'b1;
		end
		mark_rd_s1 <= mark_mem[rd_idx_q[IDX_W-1:0]];
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cfg_q       <= IN_USE_RESET;
			fit_vld_q   <= '0;
			remaining_q <= '0;
			out_valid_q <= 1'b0;
			rd_idx_q    <= '0;
			ev_vld_s1   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) cfg_q <= cfg_data;
			if (accept && (kind == KIND_LOAD)) fit_vld_q[entry_index] <= 1'b1;
			if ((state_q == ST_SUM) && walk_end) remaining_q <= sum_q;
			// take the fitness of the pick off the total
			if (hit) begin
				if (remaining_q > {{(SUM_W - FIT_W){1'b0}}, fit_s1}) begin
					remaining_q <= remaining_q - {{(SUM_W - FIT_W){1'b0}}, fit_s1};
				end else begin
					remaining_q <= '0;
				end
			end
			// walk address counter and the read-data valid stage
			if (walk_start) begin
				rd_idx_q  <= '0;
				ev_vld_s1 <= 1'b0;
			end else if (issue) begin
				rd_idx_q  <= rd_idx_q + CNT_W'(1);
				ev_vld_s1 <= 1'b1;
			end else begin
				ev_vld_s1 <= 1'b0;
			end
			if ((state_q == ST_DONE) && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (issue) ev_idx_s1 <= rd_idx_q[IDX_W-1:0];
		if (accept && (kind == KIND_DRAW)) frac_q <= random_fraction;
		if (walk_start) begin
			sum_q <= '0;
			run_q <= '0;
		end else if ((state_q == ST_SUM) && ev_vld_s1 && ({1'b0, ev_idx_s1} < n_act)) begin
			sum_q <= sum_q + {{(SUM_W - FIT_W){1'b0}}, fit_s1};
		end else if ((state_q == ST_WALK) && eligible) begin
			run_q <= run_new[SUM_W-1:0];
		end
		// target = fraction * total / 2^16, the total split into two halves
		if (state_q == ST_MUL) begin
			p_lo_s1 <= PROD_W'(frac_q * remaining_q[HALF_W-1:0]);
			p_hi_s1 <= PROD_W'(frac_q * remaining_q[SUM_W-1:HALF_W]);
		end
		if (state_q == ST_ADD) target_q <= wide_sum[FRAC_W +: SUM_W];
		// result of the draw
		if (accept && (kind == KIND_DRAW) && (remaining_q == '0)) begin
			res_pick_q   <= '0;
			res_status_q <= STATUS_EMPTY;
			res_walked_q <= '0;
		end else if (hit) begin
			res_pick_q   <= ev_idx_s1;
			res_status_q <= STATUS_OK;
			res_walked_q <= {1'b0, ev_idx_s1} + CNT_W'(1);
		end else if ((state_q == ST_WALK) && walk_end) begin
			res_pick_q   <= '0;
			res_status_q <= STATUS_EMPTY;
			res_walked_q <= rd_idx_q;
		end
		// hold the result word until taken
		if ((state_q == ST_DONE) && slot_free) begin
			out_pick_q   <= res_pick_q;
			out_status_q <= res_status_q;
			out_walked_q <= res_walked_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign picked_index   = out_pick_q;
	assign status         = out_status_q;
	assign entries_walked = out_walked_q;

`ifndef ASSERT_OFF
	a_fail_index_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == STATUS_EMPTY) |-> picked_index == '0)
		else $error("failed draw carries a nonzero index");

	a_walk_matches_pick: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == STATUS_OK)
		|-> entries_walked == ({1'b0, picked_index} + CNT_W'(1)))
		else $error("walk length does not match the picked entry");

	a_walk_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> entries_walked <= IN_USE_RESET)
		else $error("walk ran past the table");

	a_draw_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (kind == KIND_DRAW) |=> !in_ready)
		else $error("draw accepted without going busy");

	a_walk_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK) |-> rd_idx_q <= n_act)
		else $error("walk address ran past the entries in use");
`endif

endmodule

// File: verif/tb_roulette_selection_no_replace.sv
// Self-checking testbench for roulette_selection_no_replace: loads and round
// starts feed an in-bench copy of the selection wheel, and each draw's result is scored against it.
// Depends on rsnr_pkg and roulette_selection_no_replace; needs no other file.
module tb_roulette_selection_no_replace;
	import rsnr_pkg::*;

	// kind 3 is not decoded by the block; it must vanish without a result
	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

	// the settle pause outlasts a full walk and a start over 256 entries;
	// the settle pause before a register write is also handshake-free
	localparam int SETTLE_CYCLES = 300;
	localparam int QUIET_LIMIT   = 4000;
	localparam int REPORT_LIMIT  = 10;

	typedef struct packed {
		logic [IDX_W-1:0] index;
		logic             status;
		logic [CNT_W-1:0] walked;
	} pick_t;

	logic               clk;
	logic               arst_n          = 1'b0;
	logic               in_valid        = 1'b0;
	logic               in_ready;
	logic [KIND_W-1:0]  kind            = KIND_LOAD;
	logic [IDX_W-1:0]   entry_index     = '0;
	logic [FIT_W-1:0]   fitness_value   = '0;
	logic [FRAC_W-1:0]  random_fraction = '0;
	logic               out_valid;
	logic               out_ready       = 1'b0;
	logic [IDX_W-1:0]   picked_index;
	logic               status;
	logic [CNT_W-1:0]   entries_walked;
	logic               cfg_we          = 1'b0;
	logic [CNT_W-1:0]   cfg_data        = '0;

	// in-bench copy of the wheel
	logic [FIT_W-1:0]   wheel_fitness [MAX_ENTRIES];
	bit                 wheel_taken   [MAX_ENTRIES];
	logic [SUM_W-1:0]   wheel_remaining;
	logic [CNT_W-1:0]   wheel_size;
	pick_t              pending_picks [$];

	int                 send_idle_pct  = 0;
	int                 recv_stall_pct = 0;
	int                 mismatches     = 0;
	int                 quiet_cycles   = 0;

	roulette_selection_no_replace dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.kind            (kind),
		.entry_index     (entry_index),
		.fitness_value   (fitness_value),
		.random_fraction (random_fraction),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.picked_index    (picked_index),
		.status          (status),
		.entries_walked  (entries_walked),
		.cfg_we          (cfg_we),
		.cfg_data        (cfg_data)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// ------------------------------------------------------------------
	// Wheel model: apply one accepted word, queue the pick a draw produces
	// ------------------------------------------------------------------
	function automatic void advance_wheel(input logic [KIND_W-1:0] k,
			input logic [IDX_W-1:0] idx, input logic [FIT_W-1:0] fit,
			input logic [FRAC_W-1:0] frac);
		int                      span;
		int                      i;
		logic [SUM_W-1:0]        total;
		logic [SUM_W+FRAC_W-1:0] product;
		logic [SUM_W-1:0]        target;
		logic [SUM_W:0]          run;
		bit                      found;
		pick_t                   res;
		// register values past the table size clamp to the table size
		span = (wheel_size > MAX_ENTRIES) ? MAX_ENTRIES : int'(wheel_size);
		case (k)
			KIND_LOAD: begin
				// takes effect at once; the remaining total waits for the next start
				wheel_fitness[idx] = fit;
			end
			KIND_START: begin
				total = '0;
				for (i = 0; i < MAX_ENTRIES; i++) begin
					wheel_taken[i] = 1'b0;
				end
				for (i = 0; i < span; i++) begin
					total = total + wheel_fitness[i];
				end
				wheel_remaining = total;
			end
			KIND_DRAW: begin
				res.index  = '0;
				res.status = STATUS_EMPTY;
				res.walked = '0;
				found      = 1'b0;
				// an empty wheel answers at once with nothing walked
				if (wheel_remaining != 0) begin
					product = frac * wheel_remaining;
					target  = product[SUM_W+FRAC_W-1:FRAC_W];
					run     = '0;
					// a zero target lands on the first live entry, since
					// only positive fitness can stop the walk
					for (i = 0; i < span && !found; i++) begin
						res.walked = CNT_W'(i + 1);
						if (!wheel_taken[i] && wheel_fitness[i] != 0) begin
							run = run + wheel_fitness[i];
							if (run >= target) begin
								found      = 1'b1;
								res.index  = IDX_W'(i);
								res.status = STATUS_OK;
							end
						end
					end
				end
				if (found) begin
					wheel_taken[res.index] = 1'b1;
					// an entry grown during the round can exceed the total: floor at zero
					if (wheel_remaining > wheel_fitness[res.index])
						wheel_remaining = wheel_remaining - wheel_fitness[res.index];
					else
						wheel_remaining = '0;
				end else begin
					// a walk that runs off the end reports how far it got
					res.index  = '0;
					res.status = STATUS_EMPTY;
				end
				pending_picks = {pending_picks, res};
			end
			default: begin
			end
		endcase
	endfunction

	function automatic logic [FIT_W-1:0] rand_fitness();
		case ($urandom_range(9))
			0, 1:    return '0;
			2:       return '1;
			3, 4:    return FIT_W'($urandom_range(1000, 1));
			default: return FIT_W'($urandom);
		endcase
	endfunction

	function automatic logic [FRAC_W-1:0] rand_fraction();
		case ($urandom_range(9))
			0:       return '0;
			1:       return '1;
			default: return FRAC_W'($urandom);
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Sender side. Every task is entered and left right after a rising edge.
	// ------------------------------------------------------------------
	task automatic send_word(input logic [KIND_W-1:0] k, input logic [IDX_W-1:0] idx,
			input logic [FIT_W-1:0] fit, input logic [FRAC_W-1:0] frac);
		// drop valid for a random gap, or hold it high straight into the next word
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid        <= 1'b1;
		kind            <= k;
		entry_index     <= idx;
		fitness_value   <= fit;
		random_fraction <= frac;
		// hold the word until the block takes it
		do @(posedge clk); while (!in_ready);
		advance_wheel(k, idx, fit, frac);
	endtask

	// unused payload fields carry junk so the block must ignore them
	task automatic send_load(input logic [IDX_W-1:0] idx, input logic [FIT_W-1:0] fit);
		send_word(KIND_LOAD, idx, fit, FRAC_W'($urandom));
	endtask

	task automatic send_start();
		send_word(KIND_START, IDX_W'($urandom), FIT_W'($urandom), FRAC_W'($urandom));
	endtask

	task automatic send_draw(input logic [FRAC_W-1:0] frac);
		send_word(KIND_DRAW, IDX_W'($urandom), FIT_W'($urandom), frac);
	endtask

	// hold off the sender until every pending pick has come back
	task automatic drain_picks();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_picks.size() != 0);
	endtask

	// a start or load still running leaves nothing pending, so settle first
	task automatic set_wheel_size(input logic [CNT_W-1:0] size);
		drain_picks();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we   <= 1'b1;
		cfg_data <= size;
		@(posedge clk);
		cfg_we     <= 1'b0;
		wheel_size  = size;
	endtask

	// ------------------------------------------------------------------
	// Receiver side and scoring
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin : score_picks
		pick_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_picks.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("unexpected pick: index %0d status %0d walked %0d",
						picked_index, status, entries_walked);
			end else begin
				want = pending_picks.pop_front();
				if (picked_index !== want.index || status !== want.status ||
						entries_walked !== want.walked) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display("pick mismatch: index %0d/%0d status %0d/%0d walked %0d/%0d (exp/got)",
							want.index, picked_index, want.status, status,
							want.walked, entries_walked);
				end
			end
		end
	end

	// end the run if neither channel moves a word for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("no handshake for %0d cycles, %0d picks pending",
					quiet_cycles, pending_picks.size());
				$display("FAILURE");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// nothing started since reset: the draw finds an empty wheel; kind 3 is dropped
	task automatic test_unprimed_draw();
		send_draw('1);
		send_word(KIND_UNUSED, '1, '1, '1);
	endtask

	// four entries with the fitness extremes, one load outside the range in use,
	// then draw until the wheel runs dry
	task automatic test_small_round();
		set_wheel_size(CNT_W'(4));
		send_load(IDX_W'(0), '1);
		send_load(IDX_W'(2), FIT_W'(1));
		send_load(IDX_W'(3), 32'h8000_0000);
		send_load('1, 32'h1234_5678);
		send_start();
		send_draw('0);
		send_draw('1);
		send_draw(16'h8000);
		send_draw(FRAC_W'($urandom));
	endtask

	// zero entries in use, a single entry, and a value past the table size
	task automatic test_size_extremes();
		send_start();
		set_wheel_size(CNT_W'(0));
		send_draw('0);
		set_wheel_size(CNT_W'(1));
		send_start();
		send_draw('1);
		send_draw('1);
		set_wheel_size('1);
		send_start();
		send_draw(FRAC_W'(1));
	endtask

	// reload entries mid-round: a walk that runs off the end, then a pick larger
	// than what remains of the total
	task automatic test_disturbed_round();
		set_wheel_size(CNT_W'(3));
		send_load(IDX_W'(0), FIT_W'(10));
		send_load(IDX_W'(1), FIT_W'(20));
		send_load(IDX_W'(2), FIT_W'(30));
		send_start();
		send_load(IDX_W'(2), '0);
		send_draw('1);
		send_load(IDX_W'(1), '1);
		send_draw('0);
		send_draw('0);
	endtask

	// rounds of random loads, a start and draws, with some noise mixed in
	task automatic test_random_rounds(input logic [CNT_W-1:0] size, input int idle_pct,
			input int stall_pct, input int quota);
		int sent;
		int span;
		int loads;
		int draws;
		int live;
		int i;
		set_wheel_size(size);
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		span = (size > MAX_ENTRIES) ? MAX_ENTRIES : int'(size);
		sent = 0;
		while (sent < quota) begin
			// mostly load inside the range in use; now and then anywhere
			loads = $urandom_range((span < 12) ? span + 1 : 12, 1);
			repeat (loads) begin
				if ($urandom_range(7) == 0)
					send_load(IDX_W'($urandom), rand_fitness());
				else
					send_load(IDX_W'($urandom_range(span - 1)), rand_fitness());
			end
			send_start();
			live = 0;
			for (i = 0; i < span; i++) begin
				if (wheel_fitness[i] != 0)
					live++;
			end
			// one draw past the live count now and then, to empty the wheel
			draws = $urandom_range((live < 24) ? live + 1 : 24, 1);
			sent  = sent + loads + 1 + draws;
			repeat (draws) begin
				case ($urandom_range(24))
					0: begin
						send_load(IDX_W'($urandom_range(span - 1)), rand_fitness());
						sent++;
					end
					1: send_word(KIND_UNUSED, IDX_W'($urandom), FIT_W'($urandom),
						FRAC_W'($urandom));
					2: begin
						send_start();
						sent++;
					end
					default: begin
					end
				endcase
				send_draw(rand_fraction());
			end
			if ($urandom_range(7) == 0)
				drain_picks();
		end
	endtask

	initial begin : run_tests
		int i;
		for (i = 0; i < MAX_ENTRIES; i++) begin
			wheel_fitness[i] = '0;
			wheel_taken[i]   = 1'b0;
		end
		wheel_remaining = '0;
		wheel_size      = IN_USE_RESET;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_unprimed_draw();
		test_small_round();
		test_size_extremes();
		test_disturbed_round();
		test_random_rounds(CNT_W'(16),  0,  0,  350);
		test_random_rounds(CNT_W'(5),   48, 0,  350);
		test_random_rounds(CNT_W'(40),  0,  48, 350);
		test_random_rounds(CNT_W'(2),   9,  9,  250);
		test_random_rounds(CNT_W'(256), 9,  9,  300);
		test_random_rounds(CNT_W'(130), 0,  0,  200);

		// wait out the last picks, then give stray words time to show up
		drain_picks();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
